>>> hdl/tra_pkg.sv
`default_nettype none

package tra_pkg;

  typedef logic [31:0] fp32_t;

  // Pipeline depth of each arithmetic unit, in cycles.
  localparam int unsigned CLAMP_LAT = 1;
  localparam int unsigned MUL_LAT   = 3;
  localparam int unsigned ADD_LAT   = 4;
  localparam int unsigned DIV_LAT   = 16;
  localparam int unsigned PAIR_LAT  = MUL_LAT + ADD_LAT;

  // Horner steps (multiply by s, then add a coefficient) in each polynomial.
  localparam int unsigned NUM_PAIRS = 6;
  localparam int unsigned DEN_PAIRS = 3;

  localparam int unsigned S_DLY     = (NUM_PAIRS - 1) * PAIR_LAT;
  localparam int unsigned V_DLY     = MUL_LAT + NUM_PAIRS * PAIR_LAT;
  localparam int unsigned Q_DLY     = (NUM_PAIRS - DEN_PAIRS) * PAIR_LAT + MUL_LAT;
  localparam int unsigned TOTAL_LAT = CLAMP_LAT + MUL_LAT + NUM_PAIRS * PAIR_LAT
                                      + MUL_LAT + DIV_LAT;

  localparam fp32_t CLAMP_MAG  = 32'h4110_0000;   // 9.0
  localparam fp32_t QUIET_BIT  = 32'h0040_0000;
  localparam fp32_t EXP_ONES   = 32'h7F80_0000;

  // Numerator coefficients, highest power first.
  localparam fp32_t NUM_COEF [NUM_PAIRS+1] = '{
    32'hA59F_25C0,   // -2.76076847742355e-16
    32'h2A61_337E,   //  2.00018790482477e-13
    32'hAEBD_37FF,   // -8.60467152213735e-11
    32'h335C_0041,   //  5.12229709037114e-08
    32'h3779_434A,   //  1.48572235717979e-05
    32'h3A27_0DED,   //  6.37261928875436e-04
    32'h3BA0_59DC    //  4.89352455891786e-03
  };

  // Denominator coefficients, highest power first.
  localparam fp32_t DEN_COEF [DEN_PAIRS+1] = '{
    32'h35A0_D3D8,   // 1.19825839466702e-06
    32'h38F8_95D6,   // 1.18534705686654e-04
    32'h3B14_AA05,   // 2.26843463243900e-03
    32'h3BA0_59DD    // 4.89352518554385e-03
  };

  // Leading zero count of a 48-bit word; 48 for an all-zero word.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tanh_rational_approx_fp32.sv
// Single-precision tanh by a rational approximation: the input is clamped to
// [-9, 9], and an odd degree-13 numerator over an even degree-6 denominator is
// evaluated in x*x by Horner's rule, each multiply and add rounded to nearest
// even on its own, then divided. NaN inputs come out as the same NaN with the
// quiet bit set; subnormals are kept. The block is a fixed pipeline that takes
// one value every cycle while the output is not stalled; its depth is made up of
// the clamp register, the chain of eight multiplies and six adds along the
// numerator and the divider, which works out two quotient bits per stage. A
// stall on the output freezes the whole pipeline, so s_tready_o is low only
// while a result waits to be taken.
`default_nettype none

module tanh_rational_approx_fp32 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,   // [31:0] x_bits
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o    // [31:0] y_bits
);

  localparam int unsigned TOT = tra_pkg::TOTAL_LAT;
  localparam int unsigned NP  = tra_pkg::NUM_PAIRS;
  localparam int unsigned DP  = tra_pkg::DEN_PAIRS;
  localparam int unsigned PL  = tra_pkg::PAIR_LAT;

  logic           en;
  logic [TOT-1:0] vld_q;

  assign en         = ~vld_q[TOT-1] | m_tready_i;
  assign s_tready_o = en;
  assign m_tvalid_o = vld_q[TOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT-2:0], s_tvalid_i};
    end
  end

  // Clamp stage; a NaN compares above every finite or infinite magnitude.
  tra_pkg::fp32_t v_d, v_q;
  logic           big;

  always_comb begin
    big = (s_tdata_i[30:0] > tra_pkg::CLAMP_MAG[30:0]) &&
          (s_tdata_i[30:0] <= tra_pkg::EXP_ONES[30:0]);
    v_d = big ? {s_tdata_i[31], tra_pkg::CLAMP_MAG[30:0]} : s_tdata_i;
  end

  // The raw input rides along for the NaN bypass at the end.
  tra_pkg::fp32_t x_q [TOT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q    <= v_d;
      x_q[0] <= s_tdata_i;
      for (int j = 1; j < TOT; j++) x_q[j] <= x_q[j-1];
    end
  end

  tra_pkg::fp32_t s;

  tra_fmul u_sq (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (v_q),
    .b_i   (v_q),
    .y_o   (s)
  );

  tra_pkg::fp32_t s_dq [1:tra_pkg::S_DLY];
  tra_pkg::fp32_t v_dq [1:tra_pkg::V_DLY];
  tra_pkg::fp32_t q_dq [1:tra_pkg::Q_DLY];
  tra_pkg::fp32_t num_sum [NP];
  tra_pkg::fp32_t den_sum [DP];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_dq[1] <= s;
      for (int j = 2; j <= tra_pkg::S_DLY; j++) s_dq[j] <= s_dq[j-1];
      v_dq[1] <= v_q;
      for (int j = 2; j <= tra_pkg::V_DLY; j++) v_dq[j] <= v_dq[j-1];
      q_dq[1] <= den_sum[DP-1];
      for (int j = 2; j <= tra_pkg::Q_DLY; j++) q_dq[j] <= q_dq[j-1];
    end
  end

  for (genvar k = 0; k < NP; k++) begin : g_num
    tra_pkg::fp32_t acc, s_k, prod;

    if (k == 0) begin : g_first
      assign acc = tra_pkg::NUM_COEF[0];
      assign s_k = s;
    end else begin : g_next
      assign acc = num_sum[k-1];
      assign s_k = s_dq[k*PL];
    end

    tra_fmul u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (acc),
      .b_i   (s_k),
      .y_o   (prod)
    );

    tra_fadd u_add (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (prod),
      .b_i   (tra_pkg::NUM_COEF[k+1]),
      .y_o   (num_sum[k])
    );
  end

  for (genvar k = 0; k < DP; k++) begin : g_den
    tra_pkg::fp32_t acc, s_k, prod;

    if (k == 0) begin : g_first
      assign acc = tra_pkg::DEN_COEF[0];
      assign s_k = s;
    end else begin : g_next
      assign acc = den_sum[k-1];
      assign s_k = s_dq[k*PL];
    end

    tra_fmul u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (acc),
      .b_i   (s_k),
      .y_o   (prod)
    );

    tra_fadd u_add (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (prod),
      .b_i   (tra_pkg::DEN_COEF[k+1]),
      .y_o   (den_sum[k])
    );
  end

  tra_pkg::fp32_t p, y;

  tra_fmul u_odd (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (num_sum[NP-1]),
    .b_i   (v_dq[tra_pkg::V_DLY]),
    .y_o   (p)
  );

  tra_fdiv u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (p),
    .b_i   (q_dq[tra_pkg::Q_DLY]),
    .y_o   (y)
  );

  logic x_nan;

  assign x_nan     = x_q[TOT-1][30:0] > tra_pkg::EXP_ONES[30:0];
  assign m_tdata_o = x_nan ? (x_q[TOT-1] | tra_pkg::QUIET_BIT) : y;

endmodule

`default_nettype wire

>>> hdl/tra_fmul.sv
`default_nettype none

module tra_fmul (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire tra_pkg::fp32_t a_i,
  input  wire tra_pkg::fp32_t b_i,
  output tra_pkg::fp32_t      y_o
);

  logic [7:0]        ea, eb;
  logic [23:0]       ma, mb;

  logic [47:0]       prod_a_q, prod_b_q;
  logic signed [9:0] e_a_q, e_b_q;
  logic              sg_a_q, sg_b_q;
  logic [5:0]        lz_q;
  tra_pkg::fp32_t    y_q;

  assign ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
  assign eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
  assign ma = {|a_i[30:23], a_i[22:0]};
  assign mb = {|b_i[30:23], b_i[22:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q <= ma * mb;
      e_a_q    <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd127;
      sg_a_q   <= a_i[31] ^ b_i[31];
      prod_b_q <= prod_a_q;
      e_b_q    <= e_a_q;
      sg_b_q   <= sg_a_q;
      lz_q     <= tra_pkg::lzc48(prod_a_q);
    end
  end

  logic signed [9:0] ex, er, rs;
  logic [47:0]       sh;
  logic              lost, inc;
  logic [7:0]        field;
  logic [30:0]       res;
  tra_pkg::fp32_t    y_d;

  // Normalize and round; results below the normal range are shifted right
  // into the subnormal encoding before rounding.
  always_comb begin
    ex   = e_b_q + 10'sd1 - $signed({4'b0000, lz_q});
    er   = ex;
    rs   = -e_b_q;
    sh   = prod_b_q;
    lost = 1'b0;
    if (ex >= 10'sd1) begin
      sh = prod_b_q << lz_q;
    end else begin
      er = 10'sd1;
      if (e_b_q >= 10'sd0) begin
        sh = prod_b_q << e_b_q[5:0];
      end else if (rs >= 10'sd48) begin
        sh   = '0;
        lost = |prod_b_q;
      end else begin
        sh   = prod_b_q >> rs[5:0];
        lost = |(prod_b_q & ~({48{1'b1}} << rs[5:0]));
      end
    end
    field = sh[47] ? er[7:0] : 8'd0;
    inc   = sh[23] & ((|sh[22:0]) | lost | sh[24]);
    res   = {field, sh[46:24]} + {30'd0, inc};
    if (prod_b_q == 48'd0) begin
      y_d = {sg_b_q, 31'd0};
    end else if (er >= 10'sd255) begin
      y_d = {sg_b_q, tra_pkg::EXP_ONES[30:0]};
    end else begin
      y_d = {sg_b_q, res};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

>>> hdl/tra_fadd.sv
`default_nettype none

module tra_fadd (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire tra_pkg::fp32_t a_i,
  input  wire tra_pkg::fp32_t b_i,
  output tra_pkg::fp32_t      y_o
);

  logic           a_big;
  tra_pkg::fp32_t big, sml;
  logic [7:0]     e_big, e_sml;

  assign a_big = a_i[30:0] >= b_i[30:0];
  assign big   = a_big ? a_i : b_i;
  assign sml   = a_big ? b_i : a_i;
  assign e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
  assign e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];

  logic [7:0]  e_a_q, d_a_q, e_b_q, e_c_q;
  logic [23:0] mb_a_q, ms_a_q;
  logic        sgb_a_q, sgs_a_q;
  logic [27:0] sum_b_q, sum_c_q;
  logic        sg_b_q, sg_c_q;
  logic [5:0]  lz_q;

  logic [26:0] bfull, bs;
  logic [27:0] sum;

  always_comb begin
    bfull = {ms_a_q, 3'b000};
    if (d_a_q >= 8'd27) begin
      bs = {26'd0, |ms_a_q};
    end else begin
      bs = (bfull >> d_a_q[4:0]) |
           {26'd0, |(bfull & ~({27{1'b1}} << d_a_q[4:0]))};
    end
    if (sgb_a_q ^ sgs_a_q) sum = {1'b0, mb_a_q, 3'b000} - {1'b0, bs};
    else                   sum = {1'b0, mb_a_q, 3'b000} + {1'b0, bs};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_a_q   <= e_big;
      d_a_q   <= e_big - e_sml;
      mb_a_q  <= {|big[30:23], big[22:0]};
      ms_a_q  <= {|sml[30:23], sml[22:0]};
      sgb_a_q <= big[31];
      sgs_a_q <= sml[31];
      // An exact zero sum is negative only when both operands are.
      sum_b_q <= sum;
      e_b_q   <= e_a_q;
      sg_b_q  <= (sum == 28'd0) ? (sgb_a_q & sgs_a_q) : sgb_a_q;
      sum_c_q <= sum_b_q;
      e_c_q   <= e_b_q;
      sg_c_q  <= sg_b_q;
      lz_q    <= tra_pkg::lzc48({sum_b_q, 20'hFFFFF});
    end
  end

  logic signed [9:0] ex, er;
  logic [4:0]        shamt;
  logic [27:0]       sh;
  logic              inc;
  logic [7:0]        field;
  logic [30:0]       res;
  tra_pkg::fp32_t    y_d, y_q;

  always_comb begin
    ex = $signed({2'b00, e_c_q}) + 10'sd1 - $signed({4'b0000, lz_q});
    if (ex >= 10'sd1) begin
      er    = ex;
      shamt = lz_q[4:0];
    end else begin
      er    = 10'sd1;
      shamt = e_c_q[4:0];
    end
    sh    = sum_c_q << shamt;
    field = sh[27] ? er[7:0] : 8'd0;
    inc   = sh[3] & (sh[2] | sh[1] | sh[0] | sh[4]);
    res   = {field, sh[26:4]} + {30'd0, inc};
    if (sum_c_q == 28'd0) begin
      y_d = {sg_c_q, 31'd0};
    end else if (er >= 10'sd255) begin
      y_d = {sg_c_q, tra_pkg::EXP_ONES[30:0]};
    end else begin
      y_d = {sg_c_q, res};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

>>> hdl/tra_fdiv.sv
`default_nettype none

module tra_fdiv (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire tra_pkg::fp32_t a_i,
  input  wire tra_pkg::fp32_t b_i,
  output tra_pkg::fp32_t      y_o
);

  localparam int unsigned QBITS = 26;
  localparam int unsigned BPS   = 2;
  localparam int unsigned NSTG  = QBITS / BPS;

  logic [7:0]  ea_q, eb_q;
  logic [23:0] ma_q, mb_q;
  logic [5:0]  lza_q, lzb_q;
  logic        sg0_q, z0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ea_q  <= (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
      eb_q  <= (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
      ma_q  <= {|a_i[30:23], a_i[22:0]};
      mb_q  <= {|b_i[30:23], b_i[22:0]};
      lza_q <= tra_pkg::lzc48({|a_i[30:23], a_i[22:0], 24'hFFFFFF});
      lzb_q <= tra_pkg::lzc48({|b_i[30:23], b_i[22:0], 24'hFFFFFF});
      sg0_q <= a_i[31] ^ b_i[31];
      z0_q  <= (a_i[30:0] == 31'd0);
    end
  end

  // Entry 0 holds the normalized operands; entry k the state after k stages
  // of restoring division, two quotient bits per stage.
  logic [QBITS-1:0]  r_q  [NSTG+1];
  logic [QBITS-1:0]  qb_q [NSTG+1];
  logic [23:0]       nb_q [NSTG+1];
  logic signed [9:0] e_q  [NSTG+1];
  logic              sg_q [NSTG+1];
  logic              z_q  [NSTG+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= {2'b00, ma_q << lza_q[4:0]};
      qb_q[0] <= '0;
      nb_q[0] <= mb_q << lzb_q[4:0];
      e_q[0]  <= $signed({2'b00, ea_q}) - $signed({4'b0000, lza_q})
                 - $signed({2'b00, eb_q}) + $signed({4'b0000, lzb_q}) + 10'sd127;
      sg_q[0] <= sg0_q;
      z_q[0]  <= z0_q;
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic [QBITS-1:0] r_d, q_d;

    always_comb begin
      logic [QBITS-1:0] r;
      logic [QBITS-1:0] q;
      r = r_q[k];
      q = qb_q[k];
      for (int t = 0; t < BPS; t++) begin
        if (r >= {2'b00, nb_q[k]}) begin
          r = r - {2'b00, nb_q[k]};
          q = {q[QBITS-2:0], 1'b1};
        end else begin
          q = {q[QBITS-2:0], 1'b0};
        end
        r = {r[QBITS-2:0], 1'b0};
      end
      r_d = r;
      q_d = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]  <= r_d;
        qb_q[k+1] <= q_d;
        nb_q[k+1] <= nb_q[k];
        e_q[k+1]  <= e_q[k];
        sg_q[k+1] <= sg_q[k];
        z_q[k+1]  <= z_q[k];
      end
    end
  end

  logic [QBITS-1:0]  q, n, ns;
  logic              rem, lost, inc;
  logic signed [9:0] ex, er, rs;
  logic [7:0]        field;
  logic [30:0]       res;
  tra_pkg::fp32_t    y_d, y_q;

  // The top quotient bit has weight one; when it is clear the leading one
  // sits a place lower and the exponent drops by one.
  always_comb begin
    q    = qb_q[NSTG];
    rem  = |r_q[NSTG];
    n    = q[QBITS-1] ? q : {q[QBITS-2:0], 1'b0};
    ex   = q[QBITS-1] ? e_q[NSTG] : e_q[NSTG] - 10'sd1;
    er   = ex;
    rs   = 10'sd1 - ex;
    ns   = n;
    lost = 1'b0;
    if (ex < 10'sd1) begin
      er = 10'sd1;
      if (rs >= 10'sd26) begin
        ns   = '0;
        lost = |n;
      end else begin
        ns   = n >> rs[4:0];
        lost = |(n & ~({QBITS{1'b1}} << rs[4:0]));
      end
    end
    field = ns[25] ? er[7:0] : 8'd0;
    inc   = ns[1] & (ns[0] | rem | lost | ns[2]);
    res   = {field, ns[24:2]} + {30'd0, inc};
    if (z_q[NSTG]) begin
      y_d = {sg_q[NSTG], 31'd0};
    end else if (er >= 10'sd255) begin
      y_d = {sg_q[NSTG], tra_pkg::EXP_ONES[30:0]};
    end else begin
      y_d = {sg_q[NSTG], res};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

`default_nettype wire
